// File: sv/mklp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the movement key last-press priority unit.
// No dependencies; imported by every module of the block.
package mklp_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 9;
  localparam int CFG_IDX_W = 4;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  localparam logic [15:0] TYPE_SYNC = 16'd0;
  localparam logic [15:0] TYPE_KEY  = 16'd1;

  localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
  localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
  localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

  localparam logic [SLOT_W-1:0] SLOT_RESET [NUM_SLOTS] = '{
    9'd17, 9'd30, 9'd31, 9'd32, 9'd103, 9'd105, 9'd108, 9'd106
  };

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // One queued job: a passthrough event, or one/two key events each
  // followed by a sync event.
  typedef struct packed {
    logic              is_keys;
    logic              two_keys;
    logic [SLOT_W-1:0] k0_code;
    logic              k0_val;
    logic [SLOT_W-1:0] k1_code;
    logic              k1_val;
    in_item_t          pass_item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/mklp_front.sv
`timescale 1ns / 1ps
// Front end: slot code registers, held marks and active key; classifies
// each input beat and, where it yields output, pushes a job into the queue. Depends on mklp_pkg.
module mklp_front #(
  parameter int unsigned KEY_CODE_LIMIT = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mklp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mklp_pkg::SLOT_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mklp_pkg::in_item_t              in_data,
  input  mklp_pkg::q_stat_t               q_stat,
  output logic                            push,
  output mklp_pkg::cmd_t                  cmd
);
  import mklp_pkg::*;

  localparam logic [16:0] LIMIT = 17'(KEY_CODE_LIMIT);

  logic [SLOT_W-1:0] slot_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] held_r, held_nxt;
  logic [SLOT_W-1:0] active_r, active_nxt;

  logic [NUM_SLOTS-1:0] match;
  logic [NUM_SLOTS-1:0] held_rel;
  logic                 is_key, act_eq, accept, push_raw;
  logic [SLOT_W-1:0]    code9;
  logic [SLOT_W-1:0]    best;
  logic                 found;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && push_raw;
  assign code9    = in_data.event_code[SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = (in_data.event_code[15:SLOT_W] == '0) && (slot_r[i] == code9);
    end
  end

  assign is_key   = (in_data.event_type == TYPE_KEY) && (match != '0);
  assign act_eq   = ({7'b0, active_r} == in_data.event_code);
  assign held_rel = held_r & ~match;

  // Lowest held code for restore after release of the active key.
  always_comb begin
    best  = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (held_rel[i] && (slot_r[i] != '0) && ({8'b0, slot_r[i]} < LIMIT) &&
          (!found || (slot_r[i] < best))) begin
        best  = slot_r[i];
        found = 1'b1;
      end
    end
  end

  always_comb begin
    held_nxt      = held_r;
    active_nxt    = active_r;
    push_raw      = 1'b0;
    cmd           = '0;
    cmd.pass_item = in_data;
    if (!is_key) begin
      push_raw = 1'b1;
    end else if (in_data.event_value == VAL_PRESS) begin
      held_nxt = held_r | match;
      if (!act_eq) begin
        push_raw    = 1'b1;
        cmd.is_keys = 1'b1;
        if (active_r != '0) begin
          cmd.two_keys = 1'b1;
          cmd.k0_code  = active_r;
          cmd.k0_val   = 1'b0;
          cmd.k1_code  = code9;
          cmd.k1_val   = 1'b1;
        end else begin
          cmd.k0_code = code9;
          cmd.k0_val  = 1'b1;
        end
        active_nxt = code9;
      end
    end else if (in_data.event_value == VAL_RELEASE) begin
      held_nxt = held_rel;
      if (act_eq) begin
        push_raw    = 1'b1;
        cmd.is_keys = 1'b1;
        cmd.k0_code = code9;
        cmd.k0_val  = 1'b0;
        active_nxt  = '0;
        if (found) begin
          cmd.two_keys = 1'b1;
          cmd.k1_code  = best;
          cmd.k1_val   = 1'b1;
          active_nxt   = best;
        end
      end
    end else if (in_data.event_value == VAL_REPEAT) begin
      push_raw = act_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      active_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= SLOT_RESET[i];
      end
    end else begin
      if (accept) begin
        held_r   <= held_nxt;
        active_r <= active_nxt;
      end
      if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_SLOTS))) begin
        slot_r[cfg_index[2:0]] <= cfg_wdata;
      end
    end
  end

endmodule

// File: sv/mklp_queue.sv
`timescale 1ns / 1ps
// Small job FIFO between the front end and the result sequencer.
// Depends on mklp_pkg.
module mklp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mklp_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output mklp_pkg::cmd_t     head,
  output mklp_pkg::q_stat_t  stat
);
  import mklp_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/mklp_back.sv
`timescale 1ns / 1ps
// Result sequencer: expands the job at the queue head into result beats
// and holds them in the output register. Depends on mklp_pkg.
module mklp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mklp_pkg::cmd_t      head,
  input  mklp_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mklp_pkg::out_item_t out_data
);
  import mklp_pkg::*;

  logic [1:0] beat_r, beat_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, beat_item;
  logic       load, last_beat;
  logic [SLOT_W-1:0] kcode;
  logic              kval;

  assign load = !q_stat.empty && (!out_valid_r || out_ready);

  assign last_beat = !head.is_keys ||
                     (beat_r == (head.two_keys ? 2'd3 : 2'd1));
  assign pop = load && last_beat;

  assign kcode = beat_r[1] ? head.k1_code : head.k0_code;
  assign kval  = beat_r[1] ? head.k1_val  : head.k0_val;

  always_comb begin
    if (!head.is_keys) begin
      beat_item.out_type  = head.pass_item.event_type;
      beat_item.out_code  = head.pass_item.event_code;
      beat_item.out_value = head.pass_item.event_value;
    end else if (beat_r[0]) begin
      // odd beats are the sync report after each key event
      beat_item.out_type  = TYPE_SYNC;
      beat_item.out_code  = 16'd0;
      beat_item.out_value = 32'sd0;
    end else begin
      beat_item.out_type  = TYPE_KEY;
      beat_item.out_code  = {7'b0, kcode};
      beat_item.out_value = {31'b0, kval};
    end
    beat_item.last = last_beat;
  end

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      beat_nxt      = last_beat ? 2'd0 : beat_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= beat_item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/movement_key_last_press_priority_unit.sv
`timescale 1ns / 1ps
// Movement key last-press priority unit (top level). Uses mklp_pkg, mklp_front,
// mklp_queue and mklp_back.
// An input beat is written into the job queue on accept, then loaded into the
// output register when it is free. Throughput: one result beat per cycle from
// the sequencer unless out_ready stalls it; a job yields 1, 2 or 4 result
// beats, and the front accepts one per cycle while the 4-deep job queue has
// room. Synchronous active-low reset clears held marks, active key, queue and
// output valid, and loads the default slot codes.
module movement_key_last_press_priority_unit #(
  parameter int unsigned KEY_CODE_LIMIT = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mklp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mklp_pkg::SLOT_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mklp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mklp_pkg::out_item_t             out_data
);
  import mklp_pkg::*;

  logic    q_push, q_pop;
  cmd_t    q_in, q_head;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  mklp_front #(
    .KEY_CODE_LIMIT(KEY_CODE_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (q_push),
    .cmd       (q_in)
  );

  mklp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mklp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_pop_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_data.last)
    else $error("job retired without a last beat");

  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!q_stat.empty))
    else $error("result beat with no queued job");

endmodule
